/* design/lwcn_pkg.sv */
// Package for the 3x3 local contrast normalizer: states, register indexes, constants.
`default_nettype none
package lwcn_pkg;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 11;
  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_AW-1:0] REG_CHANNEL_SEL  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_GRAY_MODE    = 2'd3;
  localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [10:0] RST_FRAME_HEIGHT = 11'd480;
  localparam logic [28:0] EPS_Q16 = 29'd5898;
  localparam logic [5:0]  SQRT_STEPS = 6'd28;
  localparam logic [5:0]  DIV_STEPS  = 6'd40;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_CALC, ST_SQRT, ST_DIV, ST_FIN
  } state_t;
endpackage
`default_nettype wire

/* design/lwcn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lwcn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/local_window_contrast_normalize.sv */
// Top level of the 3x3 local contrast normalizer.
// Pixels enter on in_valid/in_ready in raster order, one beat per pixel.
// One 8-bit sample is taken per pixel (channel_select, or the low byte in
// gray mode). For each interior center a result beat carries the normalized
// value (signed, 12 fraction bits) and the center coordinates; it is sent
// when the pixel below-right of the center arrives. Border pixels give none.
// A pixel without result passes ST_READ and returns to ST_IDLE; one with a
// result runs a 28-step square root and a 40-step restoring divider, one bit per cycle.
// Both line buffers share one RAM read and written once per pixel.
// After reset a clearing pass over all MAX_WIDTH entries zeroes the line RAM;
// in_ready stays low meanwhile. cfg writes are taken at any time.
// The result sits in an output register; the next pixel is accepted while
// it waits. If the receiver stalls, a newer result holds in the final state
// and input stalls until the register frees.
`default_nettype none
module local_window_contrast_normalize #(
  parameter int MAX_WIDTH  = lwcn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lwcn_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [lwcn_pkg::CFG_AW-1:0] cfg_index,
  input  wire logic [lwcn_pkg::CFG_DW-1:0] cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [23:0]                 in_pixel,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [14:0]               out_norm_value,
  output logic [9:0]                       out_center_col,
  output logic [9:0]                       out_center_row
);
  import lwcn_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT);
  localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH = 13'(MAX_HEIGHT);

  state_t state_r, state_nxt;

  logic [10:0] width_r, height_r;
  logic [1:0]  chsel_r;
  logic        gray_r;
  logic [AW-1:0] col_r;
  logic [HW-1:0] row_r;
  logic [AW-1:0] clr_r;
  logic [7:0]  win_r [6];
  logic [7:0]  pix_r;
  logic [11:0] s_r;
  logic [19:0] q_r;
  logic signed [12:0] num_r;
  logic [55:0] v_r;
  logic [27:0] root_r;
  logic [28:0] rem_r;
  logic [39:0] nsh_r;
  logic [28:0] den_r;
  logic [28:0] drem_r;
  logic [39:0] quo_r;
  logic [5:0]  step_r;
  logic [9:0]  ccol_r, crow_r;
  logic        emit;
  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0] ram_wdata, ram_rdata;

  lwcn_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_line (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(col_r), .rdata_r(ram_rdata)
  );

  // sample select and window
  logic [1:0]  ch;
  logic [7:0]  samp;
  logic [7:0]  top, mid;
  logic [7:0]  win [9];
  logic [11:0] s_sum;
  logic [19:0] q_sum;
  logic [12:0] wcl, hcl;

  always_comb begin
    ch   = gray_r ? 2'd0 : ((chsel_r > 2'd2) ? 2'd2 : chsel_r);
    samp = in_pixel[8*ch +: 8];
    top  = ram_rdata[15:8];
    mid  = ram_rdata[7:0];
    for (int i = 0; i < 6; i++) win[i] = win_r[i];
    win[6] = top;
    win[7] = mid;
    win[8] = pix_r;
    s_sum = '0;
    q_sum = '0;
    for (int i = 0; i < 9; i++) begin
      s_sum = s_sum + 12'(win[i]);
      q_sum = q_sum + 20'(win[i]) * 20'(win[i]);
    end
    wcl = (width_r < 11'd3) ? 13'd3 : ((13'(width_r) > MAXW) ? MAXW : 13'(width_r));
    hcl = (height_r < 11'd3) ? 13'd3 : ((13'(height_r) > MAXH) ? MAXH : 13'(height_r));
    emit = (col_r >= AW'(2)) && (row_r >= HW'(2));
  end

  // iteration steps
  logic [30:0] sq_t, sq_trial;
  logic [29:0] dv_t;
  logic [23:0] d_val;
  logic [11:0] num_abs;

  always_comb begin
    sq_t     = {rem_r, v_r[55:54]};
    sq_trial = {1'b0, root_r, 2'b01};
    dv_t     = {drem_r, nsh_r[39]};
    d_val    = 24'(24'(q_r) * 24'd9 - 24'(s_r) * 24'(s_r));
    num_abs  = num_r[12] ? 12'(-num_r) : 12'(num_r);
  end

  // final sign and saturation
  logic [14:0] qsat;
  logic signed [14:0] res;
  always_comb begin
    qsat = (quo_r > 40'd16384) ? 15'd16384 : quo_r[14:0];
    if (num_r[12]) res = $signed(-qsat);
    else           res = (qsat > 15'd16383) ? 15'sd16383 : $signed(qsat);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == AW'(MAX_WIDTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_READ;
      ST_READ:  state_nxt = emit ? ST_CALC : ST_IDLE;
      ST_CALC:  state_nxt = ST_SQRT;
      ST_SQRT:  if (step_r == SQRT_STEPS - 6'd1) state_nxt = ST_DIV;
      ST_DIV:   if (step_r == DIV_STEPS - 6'd1) state_nxt = ST_FIN;
      ST_FIN:   if (!out_valid || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    ram_we    = (state_r == ST_CLEAR) || (state_r == ST_READ);
    ram_waddr = (state_r == ST_CLEAR) ? clr_r : col_r;
    ram_wdata = (state_r == ST_CLEAR) ? 16'd0 : {mid, pix_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      width_r  <= RST_FRAME_WIDTH;
      height_r <= RST_FRAME_HEIGHT;
      chsel_r  <= '0;
      gray_r   <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
      clr_r    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_r  <= cfg_data;
          REG_FRAME_HEIGHT: height_r <= cfg_data;
          REG_CHANNEL_SEL:  chsel_r  <= cfg_data[1:0];
          REG_GRAY_MODE:    gray_r   <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && (state_r != ST_FIN)) out_valid <= 1'b0;
      case (state_r)
        ST_CLEAR: clr_r <= clr_r + AW'(1);
        ST_IDLE: if (in_valid) pix_r <= samp;
        ST_READ: begin
          for (int i = 0; i < 6; i++) win_r[i] <= win[i + 3];
          s_r    <= s_sum;
          q_r    <= q_sum;
          num_r  <= 13'(13'(win[4]) * 13'd9) - 13'(s_sum);
          ccol_r <= 10'(col_r - AW'(1));
          crow_r <= 10'(row_r - HW'(1));
          if (13'(col_r) + 13'd1 >= wcl) begin
            col_r <= '0;
            if (13'(row_r) + 13'd1 >= hcl) row_r <= '0;
            else row_r <= row_r + HW'(1);
          end else begin
            col_r <= col_r + AW'(1);
          end
        end
        ST_CALC: begin
          v_r    <= {d_val, 32'd0};
          root_r <= '0;
          rem_r  <= '0;
          step_r <= '0;
        end
        ST_SQRT: begin
          v_r    <= {v_r[53:0], 2'b00};
          step_r <= step_r + 6'd1;
          if (sq_t >= sq_trial) begin
            rem_r  <= 29'(sq_t - sq_trial);
            root_r <= {root_r[26:0], 1'b1};
          end else begin
            rem_r  <= sq_t[28:0];
            root_r <= {root_r[26:0], 1'b0};
          end
          if (step_r == SQRT_STEPS - 6'd1) step_r <= '0;
        end
        ST_DIV: begin
          step_r <= step_r + 6'd1;
          nsh_r  <= {nsh_r[38:0], 1'b0};
          if (dv_t >= 30'(den_r)) begin
            drem_r <= 29'(dv_t - 30'(den_r));
            quo_r  <= {quo_r[38:0], 1'b1};
          end else begin
            drem_r <= dv_t[28:0];
            quo_r  <= {quo_r[38:0], 1'b0};
          end
        end
        ST_FIN: if (!out_valid || out_ready) begin
          out_valid      <= 1'b1;
          out_norm_value <= res;
          out_center_col <= ccol_r;
          out_center_row <= crow_r;
        end
        default: ;
      endcase
      if (state_r == ST_SQRT && step_r == SQRT_STEPS - 6'd1) begin
        den_r  <= 29'({root_r[26:0], (sq_t >= sq_trial)}) + EPS_Q16;
        nsh_r  <= {num_abs, 28'd0} +
                  40'((29'({root_r[26:0], (sq_t >= sq_trial)}) + EPS_Q16) >> 1);
        drem_r <= '0;
        quo_r  <= '0;
      end
    end
  end
endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Testbench for local_window_contrast_normalize: random pixel streams against a 3x3 predictor.
`timescale 1ns / 100ps
module tb_top;
  import lwcn_pkg::*;

  typedef struct {
    logic signed [14:0] norm;
    logic [9:0]         col;
    logic [9:0]         row;
  } norm_beat_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [23:0]       in_pixel = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [14:0] out_norm_value;
  logic [9:0]        out_center_col;
  logic [9:0]        out_center_row;

  local_window_contrast_normalize dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_norm_value(out_norm_value), .out_center_col(out_center_col),
    .out_center_row(out_center_row)
  );

  initial forever #10 clk = ~clk;

  logic [23:0] pixel_q[$];
  norm_beat_t  norm_q[$];
  int          err_count = 0;
  int          beat_count = 0;

  // shadow of the block
  logic [10:0] sh_width = RST_FRAME_WIDTH;
  logic [10:0] sh_height = RST_FRAME_HEIGHT;
  logic [1:0]  sh_chan = 2'd0;
  logic        sh_gray = 1'b0;
  logic [7:0]  row_up[DEF_MAX_WIDTH];
  logic [7:0]  row_lo[DEF_MAX_WIDTH];
  logic [7:0]  win_hist[6];
  int          col_pos = 0;
  int          row_pos = 0;

  initial begin
    foreach (row_up[i]) begin
      row_up[i] = 8'd0;
      row_lo[i] = 8'd0;
    end
    foreach (win_hist[i]) win_hist[i] = 8'd0;
  end

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned rem, res, b;
    rem = v;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int clamp_dim(logic [10:0] v);
    if (v < 3) return 3;
    if (v > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return int'(v);
  endfunction

  task automatic add_pixel(logic [23:0] pix);
    pixel_q.insert(pixel_q.size(), pix);
  endtask

  task automatic predict_norm(logic [23:0] pix);
    int w, h, ch, s, q, num, c, i;
    logic [7:0] win[9];
    longint unsigned d, den, mag, qv;
    int res;
    norm_beat_t nb;
    w = clamp_dim(sh_width);
    h = clamp_dim(sh_height);
    ch = sh_gray ? 0 : (sh_chan > 2 ? 2 : sh_chan);
    c = col_pos;
    for (i = 0; i < 6; i++) win[i] = win_hist[i];
    win[6] = row_up[c];
    win[7] = row_lo[c];
    win[8] = 8'(pix >> (8 * ch));
    if (col_pos >= 2 && row_pos >= 2) begin
      s = 0;
      q = 0;
      for (i = 0; i < 9; i++) begin
        s += win[i];
        q += win[i] * win[i];
      end
      num = 9 * win[4] - s;
      d = 64'(9 * q) - 64'(s) * 64'(s);
      den = root64(d << 32) + EPS_Q16;
      mag = 64'(num < 0 ? -num : num) << 28;
      qv = (mag + den / 2) / den;
      if (qv > 16384) qv = 16384;
      res = num < 0 ? -int'(qv) : int'(qv);
      if (res > 16383) res = 16383;
      nb.norm = res[14:0];
      nb.col = 10'(col_pos - 1);
      nb.row = 10'(row_pos - 1);
      norm_q.insert(norm_q.size(), nb);
    end
    row_up[c] = win[7];
    row_lo[c] = win[8];
    for (i = 0; i < 6; i++) win_hist[i] = win[i + 3];
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  task automatic report(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_FRAME_WIDTH:  sh_width = val;
      REG_FRAME_HEIGHT: sh_height = val;
      REG_CHANNEL_SEL:  sh_chan = val[1:0];
      REG_GRAY_MODE:    sh_gray = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (pixel_q.size() == 0 && !in_valid);
    wait (norm_q.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_cfg(int w, int h, int chan, int gray);
    write_reg(REG_FRAME_WIDTH, CFG_DW'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DW'(h));
    write_reg(REG_CHANNEL_SEL, CFG_DW'(chan));
    write_reg(REG_GRAY_MODE, CFG_DW'(gray));
  endtask

  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(0, 2);
    if (r == 1) return 2047;
    return $urandom_range(3, 10);
  endfunction

  // sender: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n && (!in_valid || in_ready)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pixel_q.size() > 0) begin
        in_valid <= 1'b1;
        in_pixel <= pixel_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 2) != 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) predict_norm(in_pixel);
  end

  always @(posedge clk) begin
    norm_beat_t e;
    if (rst_n && out_valid && out_ready) begin
      beat_count++;
      if (norm_q.size() == 0) begin
        report($sformatf("unexpected beat col %0d row %0d", out_center_col, out_center_row));
      end else begin
        e = norm_q.pop_front();
        if (out_norm_value !== e.norm)
          report($sformatf("norm got %0d exp %0d", out_norm_value, e.norm));
        if (out_center_col !== e.col)
          report($sformatf("col got %0d exp %0d", out_center_col, e.col));
        if (out_center_row !== e.row)
          report($sformatf("row got %0d exp %0d", out_center_row, e.row));
      end
    end
  end

  initial begin
    int sent, n, base, mode;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    set_cfg(3, 3, 0, 0);
    // dark frame with bright center, then bright frame with dark center
    for (int i = 0; i < 9; i++) add_pixel(i == 4 ? 24'h0000FF : 24'hFFFF00);
    for (int i = 0; i < 9; i++) add_pixel(i == 4 ? 24'hFFFF00 : 24'hFFFFFF);
    drain();
    set_cfg(3, 3, 3, 0);
    for (int i = 0; i < 9; i++) add_pixel(i == 4 ? 24'h7F0000 : 24'h80FFFF);
    drain();
    sent = 0;
    while (sent < 540) begin
      set_cfg(pick_dim(), pick_dim(), $urandom_range(0, 3), $urandom_range(0, 1));
      n = $urandom_range(30, 90);
      mode = $urandom_range(0, 3);
      base = $urandom_range(0, 255);
      for (int i = 0; i < n; i++) begin
        if (mode == 0)
          add_pixel(24'({3{8'(base + $urandom_range(0, 2))}} ^ ($urandom & 24'hFCFCFC)));
        else if (mode == 1)
          add_pixel({3{8'(base + $urandom_range(0, 3))}});
        else
          add_pixel(24'($urandom & 24'hFFFFFF));
      end
      sent += n;
      drain();
    end
    // wide frame, three rows
    set_cfg(60, 4, 1, 0);
    for (int i = 0; i < 3 * 60; i++) add_pixel(24'($urandom & 24'hFFFFFF));
    drain();
    $display("covered %0d random pixels plus a wide-frame stretch, %0d result beats checked",
             sent, beat_count);
    $display("sizes clamped low and high, all channel selects and gray mode exercised");
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end
endmodule
